FILE: src/cbp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the correlated two-bit branch predictor.
// No dependencies; used by cbp_ram users and the top level by scoped names.
package cbp_pkg;

  // Fixed field widths
  localparam int unsigned AddrW = 32;
  localparam int unsigned CountW = 32;

  // Two-bit counter states
  localparam logic [1:0] CTR_STRONG_NT = 2'd0;
  localparam logic [1:0] CTR_WEAK_NT   = 2'd1;
  localparam logic [1:0] CTR_WEAK_T    = 2'd2;
  localparam logic [1:0] CTR_STRONG_T  = 2'd3;

  // One table word: valid flag and counter state
  typedef struct packed {
    logic       valid;
    logic [1:0] ctr;
  } entry_t;

  // Counter update; a weakly taken entry that misses drops straight to strong not taken
  function automatic logic [1:0] next_ctr(input logic [1:0] ctr, input logic taken);
    logic [1:0] res;
    case (ctr)
      CTR_STRONG_NT: res = taken ? CTR_WEAK_NT : CTR_STRONG_NT;
      CTR_WEAK_NT:   res = taken ? CTR_STRONG_T : CTR_STRONG_NT;
      CTR_WEAK_T:    res = taken ? CTR_STRONG_T : CTR_STRONG_NT;
      CTR_STRONG_T:  res = taken ? CTR_STRONG_T : CTR_WEAK_NT;
      default:       res = CTR_STRONG_NT;
    endcase
    return res;
  endfunction

endpackage

FILE: src/cbp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cbp_ram #(
  parameter int unsigned Width = 3,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port (old data on a same-address write)
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/correlated_two_bit_branch_predictor.sv
`timescale 1ns / 1ps
// Correlated (gshare style) two-bit branch predictor, top level.
// Depends on cbp_pkg and cbp_ram.
//
// Usage:
//   A beat is offered on branch_addr_i / taken_i with start_i; it is taken at
//   a rising edge where start_i is high and busy_o is low. One result beat per
//   input beat appears via the s1_valid_q and done_q registers, held for
//   exactly one cycle with done_o high; the receiver cannot stall it.
//   Throughput is one beat per cycle while busy_o is low. Each beat reads its
//   table word in the cycle it is taken (RAM read port) and writes it back the
//   next cycle; a bypass register covers a read and write of the same word at
//   one edge.
//   Reset: history and the right/wrong counts clear at once. The table is then
//   swept, one word per cycle, writing every word as invalid: busy_o stays
//   high until the sweep has written the last word.
//   Counts saturate at all ones. The table index is the low TABLE_BITS of
//   branch_addr_i XOR the zero-extended global history.
module correlated_two_bit_branch_predictor #(
  parameter int unsigned HISTORY_BITS = 3,
  parameter int unsigned TABLE_BITS   = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [cbp_pkg::AddrW-1:0]   branch_addr_i,
  input  logic                        taken_i,
  output logic                        done_o,
  output logic                        predicted_taken_o,
  output logic                        was_correct_o,
  output logic                        first_seen_o,
  output logic [cbp_pkg::CountW-1:0]  right_total_o,
  output logic [cbp_pkg::CountW-1:0]  wrong_total_o
);

  localparam int unsigned Depth = 1 << TABLE_BITS;
  localparam int unsigned EntW  = $bits(cbp_pkg::entry_t);

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  logic                      state_q, state_d;
  logic [TABLE_BITS-1:0]     clr_idx_q, clr_idx_d;
  logic [HISTORY_BITS-1:0]   hist_q, hist_d;
  logic [HISTORY_BITS:0]     hist_shift;
  logic [cbp_pkg::AddrW-1:0] hist_ext;
  logic                      accept;
  logic [TABLE_BITS-1:0]     rd_idx;

  logic                      s1_valid_q;
  logic [TABLE_BITS-1:0]     s1_idx_q;
  logic                      s1_taken_q;

  logic                      fwd_valid_q;
  logic [TABLE_BITS-1:0]     fwd_idx_q;
  cbp_pkg::entry_t           fwd_ent_q;

  logic [EntW-1:0]           ram_rdata;
  cbp_pkg::entry_t           cur_ent;
  cbp_pkg::entry_t           new_ent;
  logic                      first;
  logic                      pred;
  logic                      correct;

  logic                      ram_we;
  logic [TABLE_BITS-1:0]     ram_waddr;
  logic [EntW-1:0]           ram_wdata;

  logic [cbp_pkg::CountW-1:0] right_q, right_d;
  logic [cbp_pkg::CountW-1:0] wrong_q, wrong_d;

  logic                      done_q;
  logic                      pred_q;
  logic                      correct_q;
  logic                      first_q;

  // Clearing sweep, then run
  assign busy_o = (state_q != ST_RUN);
  assign accept = start_i & ~busy_o;

  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == TABLE_BITS'(Depth - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Index and history update at accept
  assign hist_ext   = {{(cbp_pkg::AddrW - HISTORY_BITS){1'b0}}, hist_q};
  assign rd_idx     = branch_addr_i[TABLE_BITS-1:0] ^ hist_ext[TABLE_BITS-1:0];
  assign hist_shift = {hist_q, taken_i};
  assign hist_d     = accept ? hist_shift[HISTORY_BITS-1:0] : hist_q;

  // Stage 1: entry lookup with same-word bypass
  assign cur_ent = (fwd_valid_q && (fwd_idx_q == s1_idx_q))
                   ? fwd_ent_q : cbp_pkg::entry_t'(ram_rdata);
  assign first   = ~cur_ent.valid;
  assign pred    = cur_ent.valid & cur_ent.ctr[1];
  assign correct = (pred == s1_taken_q);

  always_comb begin
    new_ent.valid = 1'b1;
    new_ent.ctr   = first ? cbp_pkg::CTR_STRONG_NT
                          : cbp_pkg::next_ctr(cur_ent.ctr, s1_taken_q);
  end

  // Table write: sweep during clear, write-back in run
  assign ram_we    = (state_q == ST_CLEAR) | s1_valid_q;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_idx_q : s1_idx_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : EntW'(new_ent);

  cbp_ram #(
    .Width (EntW),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // Saturating right/wrong counts
  always_comb begin
    right_d = right_q;
    wrong_d = wrong_q;
    if (s1_valid_q) begin
      if (correct) begin
        if (right_q != '1) begin
          right_d = right_q + 1'b1;
        end
      end else begin
        if (wrong_q != '1) begin
          wrong_d = wrong_q + 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      hist_q      <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      done_q      <= 1'b0;
      right_q     <= '0;
      wrong_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      hist_q      <= hist_d;
      s1_valid_q  <= accept;
      fwd_valid_q <= s1_valid_q;
      done_q      <= s1_valid_q;
      right_q     <= right_d;
      wrong_q     <= wrong_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s1_idx_q   <= rd_idx;
    s1_taken_q <= taken_i;
    fwd_idx_q  <= s1_idx_q;
    fwd_ent_q  <= new_ent;
    pred_q     <= pred;
    correct_q  <= correct;
    first_q    <= first;
  end

  assign done_o            = done_q;
  assign predicted_taken_o = pred_q;
  assign was_correct_o     = correct_q;
  assign first_seen_o      = first_q;
  assign right_total_o     = right_q;
  assign wrong_total_o     = wrong_q;

endmodule

FILE: tb/correlated_two_bit_branch_predictor_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the correlated two-bit branch predictor: directed and random beats.
// Depends on cbp_pkg and the predictor RTL; a local predictor checks every result beat.
module correlated_two_bit_branch_predictor_tb;

  localparam int unsigned HIST_W  = 3;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned ENTRIES = 1 << IDX_W;
  localparam int unsigned LIMIT   = 200000;

  // Expected contents of one result beat
  typedef struct {
    logic        predicted;
    logic        correct;
    logic        first;
    logic [31:0] right_total;
    logic [31:0] wrong_total;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] branch_addr_i;
  logic        taken_i;
  logic        done_o;
  logic        predicted_taken_o;
  logic        was_correct_o;
  logic        first_seen_o;
  logic [31:0] right_total_o;
  logic [31:0] wrong_total_o;

  // Shadow predictor state
  logic [HIST_W-1:0] ghr;
  logic [1:0]        pht_state [ENTRIES];
  logic              pht_valid [ENTRIES];
  logic [31:0]       hits;
  logic [31:0]       misses;

  outcome_t    pending_outcomes[$];
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_first;
  int unsigned n_mismatch;
  int unsigned cycles;

  correlated_two_bit_branch_predictor #(
    .HISTORY_BITS(HIST_W),
    .TABLE_BITS  (IDX_W)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .branch_addr_i    (branch_addr_i),
    .taken_i          (taken_i),
    .done_o           (done_o),
    .predicted_taken_o(predicted_taken_o),
    .was_correct_o    (was_correct_o),
    .first_seen_o     (first_seen_o),
    .right_total_o    (right_total_o),
    .wrong_total_o    (wrong_total_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycles,
               pending_outcomes.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void clear_predictor();
    ghr    = '0;
    hits   = '0;
    misses = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      pht_valid[i] = 1'b0;
      pht_state[i] = cbp_pkg::CTR_STRONG_NT;
    end
  endfunction

  // Two-bit counter step; weakly taken is never entered
  function automatic logic [1:0] step_counter(input logic [1:0] st, input logic tk);
    logic [1:0] nxt;
    case (st)
      cbp_pkg::CTR_STRONG_NT: nxt = tk ? cbp_pkg::CTR_WEAK_NT  : cbp_pkg::CTR_STRONG_NT;
      cbp_pkg::CTR_WEAK_NT:   nxt = tk ? cbp_pkg::CTR_STRONG_T : cbp_pkg::CTR_STRONG_NT;
      cbp_pkg::CTR_WEAK_T:    nxt = tk ? cbp_pkg::CTR_STRONG_T : cbp_pkg::CTR_STRONG_NT;
      default:                nxt = tk ? cbp_pkg::CTR_STRONG_T : cbp_pkg::CTR_WEAK_NT;
    endcase
    return nxt;
  endfunction

  // Resolve one branch against the shadow state and return the expected result
  function automatic outcome_t resolve_branch(input logic [31:0] addr, input logic tk);
    outcome_t          o;
    logic [IDX_W-1:0]  idx;
    idx     = addr[IDX_W-1:0] ^ {{(IDX_W-HIST_W){1'b0}}, ghr};
    o.first = !pht_valid[idx];
    if (o.first) begin
      o.predicted    = 1'b0;
      pht_valid[idx] = 1'b1;
      pht_state[idx] = cbp_pkg::CTR_STRONG_NT;
      n_first++;
    end else begin
      o.predicted    = pht_state[idx][1];
      pht_state[idx] = step_counter(pht_state[idx], tk);
    end
    o.correct = (o.predicted == tk);
    if (o.correct) begin
      if (hits != '1) hits++;
    end else begin
      if (misses != '1) misses++;
    end
    o.right_total = hits;
    o.wrong_total = misses;
    ghr = {ghr[HIST_W-2:0], tk};
    return o;
  endfunction

  // Address that lands on a chosen table entry under the current history
  function automatic logic [31:0] entry_addr(input logic [IDX_W-1:0] target,
                                             input logic [31:0] upper);
    logic [IDX_W-1:0] low;
    low = target ^ {{(IDX_W-HIST_W){1'b0}}, ghr};
    return {upper[31:IDX_W], low};
  endfunction

  // Offer one beat and hold it until taken
  task automatic send_branch(input logic [31:0] addr, input logic tk);
    start_i       <= 1'b1;
    branch_addr_i <= addr;
    taken_i       <= tk;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_outcomes.push_back(resolve_branch(addr, tk));
    n_sent++;
  endtask

  // Sender gap; data lines carry junk meanwhile
  task automatic idle_cycles(input int unsigned n);
    if (n != 0) begin
      start_i       <= 1'b0;
      branch_addr_i <= $urandom;
      taken_i       <= 1'($urandom_range(1));
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch on beat %0d, %s: expected %0h, got %0h", n_checked, name, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    outcome_t want;
    if (done_o === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("result beat with nothing outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        check_field("predicted_taken", 32'(want.predicted), 32'(predicted_taken_o));
        check_field("was_correct", 32'(want.correct), 32'(was_correct_o));
        check_field("first_seen", 32'(want.first), 32'(first_seen_o));
        check_field("right_total", want.right_total, right_total_o);
        check_field("wrong_total", want.wrong_total, wrong_total_o);
        n_checked++;
      end
    end
  end

  // Cold table: both address extremes, both outcomes
  task automatic test_cold_entries();
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
  endtask

  // Walk one entry through every reachable state with both outcomes
  task automatic test_counter_walk();
    logic [10:0] pattern;
    pattern = 11'b01000101110;
    for (int i = 0; i < 11; i++)
      send_branch(entry_addr(IDX_W'(5), $urandom), pattern[i]);
  endtask

  // Different upper address bits sharing an entry
  task automatic test_aliasing();
    send_branch(entry_addr(IDX_W'(9), 32'hFFFF_FFFF), 1'b1);
    send_branch(entry_addr(IDX_W'(9), 32'h0000_0000), 1'b1);
    send_branch(entry_addr(IDX_W'(9), 32'h8000_0000), 1'b1);
    send_branch(entry_addr(IDX_W'(9), 32'h7FFF_FFFF), 1'b0);
  endtask

  // Loop-like traffic on a few hot entries, with some scattered branches
  task automatic test_random_phase(input int unsigned n, input int unsigned idle_pct);
    logic [IDX_W-1:0] hot [12];
    int unsigned      bias [12];
    int unsigned      k;
    for (int i = 0; i < 12; i++) begin
      hot[i] = IDX_W'($urandom);
      case ($urandom_range(2))
        0:       bias[i] = 5;
        1:       bias[i] = 50;
        default: bias[i] = 95;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75) begin
        k = $urandom_range(11);
        send_branch(entry_addr(hot[k], $urandom), $urandom_range(99) < bias[k]);
      end else begin
        send_branch($urandom, 1'($urandom_range(1)));
      end
      if ($urandom_range(99) < idle_pct) idle_cycles($urandom_range(1, 4));
    end
  endtask

  // Stop offering until every outstanding beat has come back
  task automatic test_drain_pause();
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    branch_addr_i = '0;
    taken_i       = 1'b0;
    cycles        = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_first       = 0;
    n_mismatch    = 0;
    clear_predictor();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_cold_entries();
    test_counter_walk();
    test_aliasing();
    test_random_phase(400, 0);
    test_random_phase(400, 75);
    test_drain_pause();
    test_random_phase(400, 29);
    test_random_phase(300, 0);

    // Let the last beats come back
    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("%0d branches resolved, %0d results checked, %0d cold entries, %0d mispredicts",
             n_sent, n_checked, n_first, misses);
    $display("%0d field mismatches", n_mismatch);
    if (n_mismatch == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
